FILE: rtl/core/zpv_pkg.sv
// Shared types, codes, reset constants and the sequencer program of the viewport projector.
package zpv_pkg;

   // Field widths
   localparam int unsigned PIX_W   = 13;
   localparam int unsigned POS_W   = 64;
   localparam int unsigned SCALE_W = 40;
   localparam int unsigned ZF_W    = 16;
   localparam int unsigned WIN_W   = 13;
   localparam int unsigned SCR_W   = 16;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned CSR_W   = 40;
   localparam int unsigned UPC_W   = 6;

   // Multiplier operand widths: |pixel| * scale fits in MUL_A_W bits, 1 - factor needs 17
   localparam int unsigned MUL_A_W = 53;
   localparam int unsigned MUL_B_W = 17;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
   localparam int unsigned FRAC_W  = 16;

   // Divider
   localparam int unsigned DIV_CNT_W    = 6;
   localparam int unsigned DIV_NARROW_Q = 16;
   localparam int unsigned DIV_WIDE_Q   = 40;

   // Request codes
   localparam logic [2:0] REQ_PROJECT  = 3'd0;
   localparam logic [2:0] REQ_ZOOM_IN  = 3'd1;
   localparam logic [2:0] REQ_ZOOM_OUT = 3'd2;
   localparam logic [2:0] REQ_PAN      = 3'd3;
   localparam logic [2:0] REQ_INIT     = 3'd4;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_ZOOM_FACTOR   = 3'd0;
   localparam logic [IDX_W-1:0] CSR_MIN_SCALE     = 3'd1;
   localparam logic [IDX_W-1:0] CSR_MAX_SCALE     = 3'd2;
   localparam logic [IDX_W-1:0] CSR_INITIAL_SCALE = 3'd3;
   localparam logic [IDX_W-1:0] CSR_WINDOW_WIDTH  = 3'd4;
   localparam logic [IDX_W-1:0] CSR_WINDOW_HEIGHT = 3'd5;

   // Register reset values
   localparam logic [ZF_W-1:0]    ZF_RESET    = 16'd58982;
   localparam logic [SCALE_W-1:0] MIN_RESET   = 40'd1;
   localparam logic [SCALE_W-1:0] MAX_RESET   = 40'hFF_FFFF_FFFF;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 40'd65536;
   localparam logic [WIN_W-1:0]   WIDTH_RESET = 13'd1024;
   localparam logic [WIN_W-1:0]   HEIGHT_RESET = 13'd768;

   localparam logic [POS_W-1:0] ORIGIN_X_RESET =
      64'd0 - ((64'(WIDTH_RESET) * 64'(SCALE_RESET)) >> 1);
   localparam logic [POS_W-1:0] ORIGIN_Y_RESET =
      64'd0 - ((64'(HEIGHT_RESET) * 64'(SCALE_RESET)) >> 1);

   localparam logic [SCR_W-1:0] SCR_POS_LIMIT = 16'd32767;
   localparam logic [SCR_W-1:0] SCR_NEG_LIMIT = 16'd32768;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_REFUSE = 2'd1,
      ST_SAT    = 2'd2
   } status_type;

   typedef enum logic {
      A_SCALE = 1'b0,
      A_PROD  = 1'b1
   } a_sel_type;

   typedef enum logic [1:0] {
      B_PIX = 2'd0,
      B_ZF  = 2'd1,
      B_K   = 2'd2,
      B_WIN = 2'd3
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE = 2'd0,
      ACC_ADD  = 2'd1,
      ACC_SUB  = 2'd2,
      ACC_INIT = 2'd3
   } acc_type;

   typedef enum logic [1:0] {
      NS_NONE = 2'd0,
      NS_MUL  = 2'd1,
      NS_DIV  = 2'd2
   } ns_sel_type;

   typedef enum logic [1:0] {
      SC_NONE = 2'd0,
      SC_NS   = 2'd1,
      SC_INIT = 2'd2
   } sc_sel_type;

   typedef enum logic [1:0] {
      DIV_NONE = 2'd0,
      DIV_PROJ = 2'd1,
      DIV_ZOOM = 2'd2
   } div_op_type;

   typedef enum logic [1:0] {
      J_NONE    = 2'd0,
      J_NS_LOW  = 2'd1,
      J_ZF_ZERO = 2'd2,
      J_NS_HIGH = 2'd3
   } jmp_type;

   typedef struct packed {
      logic             mul_en;
      a_sel_type        a_sel;
      b_sel_type        b_sel;
      logic             axis;
      acc_type          acc;
      logic             sh16;
      ns_sel_type       ns_sel;
      sc_sel_type       sc_sel;
      div_op_type       div_op;
      logic             wait_div;
      logic             store_scr;
      jmp_type          jmp;
      logic [UPC_W-1:0] target;
      logic             finish;
      logic             refuse;
   } ucw_type;

   typedef struct packed {
      logic start;
      logic wide;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic ovf;
   } div_stat_type;

   // Program entry points
   localparam logic [UPC_W-1:0] UA_PROJECT  = 6'd0;
   localparam logic [UPC_W-1:0] UA_ZOOM_IN  = 6'd6;
   localparam logic [UPC_W-1:0] UA_ZOOM_OUT = 6'd15;
   localparam logic [UPC_W-1:0] UA_PAN      = 6'd27;
   localparam logic [UPC_W-1:0] UA_INIT     = 6'd31;
   localparam logic [UPC_W-1:0] UA_DONE     = 6'd36;
   localparam logic [UPC_W-1:0] UA_REFUSE   = 6'd37;

   localparam ucw_type UCW_NOP = '{
      mul_en: 1'b0, a_sel: A_SCALE, b_sel: B_PIX, axis: 1'b0, acc: ACC_NONE,
      sh16: 1'b0, ns_sel: NS_NONE, sc_sel: SC_NONE, div_op: DIV_NONE,
      wait_div: 1'b0, store_scr: 1'b0, jmp: J_NONE, target: 6'd0,
      finish: 1'b0, refuse: 1'b0};

   function automatic logic [UPC_W-1:0] entry_addr(input logic [2:0] code);
      logic [UPC_W-1:0] a;
      case (code)
         REQ_PROJECT:  a = UA_PROJECT;
         REQ_ZOOM_IN:  a = UA_ZOOM_IN;
         REQ_ZOOM_OUT: a = UA_ZOOM_OUT;
         REQ_PAN:      a = UA_PAN;
         REQ_INIT:     a = UA_INIT;
         default:      a = UA_DONE;
      endcase
      return a;
   endfunction

   // Control store: one word per step
   function automatic ucw_type ucode(input logic [UPC_W-1:0] addr);
      ucw_type w;
      w = UCW_NOP;
      case (addr)
         // project: divide each axis distance by the scale
         6'd0:  begin w.div_op = DIV_PROJ; end
         6'd1:  begin w.wait_div = 1'b1; end
         6'd2:  begin w.store_scr = 1'b1; end
         6'd3:  begin w.div_op = DIV_PROJ; w.axis = 1'b1; end
         6'd4:  begin w.wait_div = 1'b1; w.axis = 1'b1; end
         6'd5:  begin w.store_scr = 1'b1; w.axis = 1'b1; w.finish = 1'b1; end
         // zoom in
         6'd6:  begin w.mul_en = 1'b1; w.b_sel = B_ZF; end
         6'd7:  begin w.ns_sel = NS_MUL; end
         6'd8:  begin w.jmp = J_NS_LOW; w.target = UA_REFUSE; end
         6'd9:  begin w.mul_en = 1'b1; end
         6'd10: begin w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_K; end
         6'd11: begin w.acc = ACC_ADD; w.sh16 = 1'b1; end
         6'd12: begin w.mul_en = 1'b1; w.axis = 1'b1; end
         6'd13: begin w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_K; end
         6'd14: begin
            w.acc = ACC_ADD; w.sh16 = 1'b1; w.axis = 1'b1;
            w.sc_sel = SC_NS; w.finish = 1'b1;
         end
         // zoom out
         6'd15: begin w.jmp = J_ZF_ZERO; w.target = UA_REFUSE; end
         6'd16: begin w.div_op = DIV_ZOOM; end
         6'd17: begin w.wait_div = 1'b1; end
         6'd18: begin w.ns_sel = NS_DIV; end
         6'd19: begin w.jmp = J_NS_HIGH; w.target = UA_REFUSE; end
         6'd20: begin w.sc_sel = SC_NS; end
         6'd21: begin w.mul_en = 1'b1; end
         6'd22: begin w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_K; end
         6'd23: begin w.acc = ACC_SUB; w.sh16 = 1'b1; end
         6'd24: begin w.mul_en = 1'b1; w.axis = 1'b1; end
         6'd25: begin w.mul_en = 1'b1; w.a_sel = A_PROD; w.b_sel = B_K; end
         6'd26: begin w.acc = ACC_SUB; w.sh16 = 1'b1; w.axis = 1'b1; w.finish = 1'b1; end
         // pan
         6'd27: begin w.mul_en = 1'b1; end
         6'd28: begin w.acc = ACC_ADD; end
         6'd29: begin w.mul_en = 1'b1; w.axis = 1'b1; end
         6'd30: begin w.acc = ACC_ADD; w.axis = 1'b1; w.finish = 1'b1; end
         // init view
         6'd31: begin w.sc_sel = SC_INIT; end
         6'd32: begin w.mul_en = 1'b1; w.b_sel = B_WIN; end
         6'd33: begin w.acc = ACC_INIT; end
         6'd34: begin w.mul_en = 1'b1; w.b_sel = B_WIN; w.axis = 1'b1; end
         6'd35: begin w.acc = ACC_INIT; w.axis = 1'b1; w.finish = 1'b1; end
         // common tails
         6'd36: begin w.finish = 1'b1; end
         6'd37: begin w.refuse = 1'b1; w.finish = 1'b1; end
         default: begin w.finish = 1'b1; end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/zpv_if.sv
// Handshake channels of the viewport projector: request, response and register write.
interface zpv_req_if import zpv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [2:0]              req_type;
   logic signed [PIX_W-1:0] pixel_x;
   logic signed [PIX_W-1:0] pixel_y;
   logic signed [POS_W-1:0] body_x;
   logic signed [POS_W-1:0] body_y;

   modport source (output valid, req_type, pixel_x, pixel_y, body_x, body_y, input ready);
   modport sink   (input valid, req_type, pixel_x, pixel_y, body_x, body_y, output ready);
endinterface

interface zpv_rsp_if import zpv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SCR_W-1:0] screen_x;
   logic signed [SCR_W-1:0] screen_y;
   logic [1:0]              status;

   modport source (output valid, screen_x, screen_y, status, input ready);
   modport sink   (input valid, screen_x, screen_y, status, output ready);
endinterface

interface zpv_csr_if import zpv_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CSR_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/zpv_divider.sv
// Restoring divider, one quotient bit per cycle, with up-front quotient overflow check.
module zpv_divider import zpv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_cmd_type        cmd,
   input  logic [POS_W-1:0]   dividend,
   input  logic [SCALE_W-1:0] divisor,
   output div_stat_type       stat,
   output logic [SCALE_W-1:0] quotient
);

   logic [SCALE_W-1:0]   rem_ff, rem_in;
   logic [POS_W-1:0]     low_ff, low_in;
   logic [SCALE_W-1:0]   quo_ff, quo_in;
   logic [SCALE_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;

   logic [POS_W-1:0]   head;
   logic [SCALE_W:0]   trial;
   logic [SCALE_W:0]   diff;
   logic               fits;

   // Part of the dividend above the quotient bits; it must stay below the divisor
   assign head  = cmd.wide ? (dividend >> DIV_WIDE_Q) : (dividend >> DIV_NARROW_Q);
   assign trial = {rem_ff, low_ff[POS_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.start) begin
         ovf_in = head >= POS_W'(divisor);
         rem_in = head[SCALE_W-1:0];
         low_in = cmd.wide ? (dividend << (POS_W - DIV_WIDE_Q))
                           : (dividend << (POS_W - DIV_NARROW_Q));
         quo_in = '0;
         dvs_in = divisor;
         if (head >= POS_W'(divisor)) begin
            cnt_in = '0;
         end else begin
            cnt_in = cmd.wide ? DIV_CNT_W'(DIV_WIDE_Q) : DIV_CNT_W'(DIV_NARROW_Q);
         end
      end else if (cnt_ff != '0) begin
         rem_in = fits ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
         low_in = low_ff << 1;
         quo_in = {quo_ff[SCALE_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = cnt_ff != '0;
   assign stat.ovf  = ovf_ff;
   assign quotient  = quo_ff;

endmodule

FILE: rtl/core/zoom_pan_viewport_projector.sv
// Top level of the zoom and pan viewport projector: sequencer, datapath and view state.
//
//   channel   dir  beat contents                                   accepted when
//   req_ch    in   req_type, pixel_x, pixel_y, body_x, body_y      valid && ready
//   rsp_ch    out  screen_x, screen_y, status                      valid && ready
//   csr_ch    in   index, data                                     valid && ready (ready held high)
//
// Project runs two 16-bit divisions on the shared divider, one quotient bit a cycle; zoom
// out runs a 40-bit division of the scale by the factor.
// One request is worked at a time; a new one is taken as soon as the sequencer goes idle,
// even while the previous response still waits in the output register.
// Reset is synchronous: view state comes up centered at the reset scale, no clearing pass.
// A stalled response holds the sequencer on its last step until the output register frees.
module zoom_pan_viewport_projector import zpv_pkg::*; (
   input logic       clock,
   input logic       reset,
   zpv_req_if.sink   req_ch,
   zpv_rsp_if.source rsp_ch,
   zpv_csr_if.sink   csr_ch
);

   // ---------------------------------------------------------------- registers
   // configuration
   logic [ZF_W-1:0]    zf_ff, zf_in;
   logic [SCALE_W-1:0] min_ff, min_in;
   logic [SCALE_W-1:0] max_ff, max_in;
   logic [SCALE_W-1:0] init_ff, init_in;
   logic [WIN_W-1:0]   win_w_ff, win_w_in;
   logic [WIN_W-1:0]   win_h_ff, win_h_in;

   // view state
   logic [POS_W-1:0]   org_x_ff, org_x_in;
   logic [POS_W-1:0]   org_y_ff, org_y_in;
   logic [SCALE_W-1:0] view_scale_ff, view_scale_in;

   // sequencer
   logic               run_ff, run_in;
   logic [UPC_W-1:0]   upc_ff, upc_in;

   // request beat held while it is worked
   logic [PIX_W-1:0]   px_ff, px_in;
   logic [PIX_W-1:0]   py_ff, py_in;
   logic [POS_W-1:0]   bx_ff, bx_in;
   logic [POS_W-1:0]   by_ff, by_in;

   // datapath
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SCALE_W-1:0] ns_ff, ns_in;
   logic               sign_ff, sign_in;
   logic               neg_ff, neg_in;
   logic [SCR_W-1:0]   scr_x_ff, scr_x_in;
   logic [SCR_W-1:0]   scr_y_ff, scr_y_in;
   status_type         stat_ff, stat_in;

   // response output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCR_W-1:0]   out_x_ff, out_x_in;
   logic [SCR_W-1:0]   out_y_ff, out_y_in;
   status_type         out_st_ff, out_st_in;

   // ---------------------------------------------------------------- control word
   ucw_type            cw;
   logic               hold;
   logic               step;
   logic               take_jump;
   logic               req_fire;
   div_cmd_type        div_cmd;
   div_stat_type       div_stat;

   assign cw       = ucode(upc_ff);
   assign req_fire = req_ch.valid && !run_ff;
   // stall on a busy divider, or on a full output register at the last step
   assign hold     = (cw.wait_div && div_stat.busy)
                     || (cw.finish && rsp_valid_ff && !rsp_ch.ready);
   assign step     = run_ff && !hold;

   // ---------------------------------------------------------------- divider
   logic [POS_W-1:0]   div_dividend;
   logic [SCALE_W-1:0] div_divisor;
   logic [SCALE_W-1:0] div_quo;

   // project distance: body minus origin, kept as sign and 64-bit magnitude
   logic [POS_W-1:0]   body_sel;
   logic [POS_W-1:0]   org_sel;
   logic [POS_W:0]     span;
   logic               dist_neg;
   logic [POS_W-1:0]   dist_mag;

   assign body_sel = cw.axis ? by_ff : bx_ff;
   assign org_sel  = cw.axis ? org_y_ff : org_x_ff;
   assign span     = {body_sel[POS_W-1], body_sel} - {org_sel[POS_W-1], org_sel};
   assign dist_neg = span[POS_W];
   assign dist_mag = dist_neg ? POS_W'((POS_W+1)'(0) - span) : span[POS_W-1:0];

   assign div_cmd.start = step && (cw.div_op != DIV_NONE);
   assign div_cmd.wide  = cw.div_op == DIV_ZOOM;
   // zoom out: (scale << 16) / factor; project: distance / scale
   assign div_dividend  = div_cmd.wide ? {8'd0, view_scale_ff, 16'd0} : dist_mag;
   assign div_divisor   = div_cmd.wide ? {24'd0, zf_ff} : view_scale_ff;

   zpv_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------- multiplier
   logic [PIX_W-1:0]   pix_sel;
   logic               pix_neg;
   logic [PIX_W-1:0]   pix_mag;
   logic [MUL_B_W-1:0] k_val;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;

   assign pix_sel = cw.axis ? py_ff : px_ff;
   assign pix_neg = pix_sel[PIX_W-1];
   // -(-4096) still fits as an unsigned 13-bit magnitude
   assign pix_mag = pix_neg ? PIX_W'(PIX_W'(0) - pix_sel) : pix_sel;
   assign k_val   = MUL_B_W'(1 << FRAC_W) - {1'b0, zf_ff};
   assign mul_a   = (cw.a_sel == A_PROD) ? prod_ff[MUL_A_W-1:0]
                                         : {{(MUL_A_W-SCALE_W){1'b0}}, view_scale_ff};

   always_comb begin
      case (cw.b_sel)
         B_PIX:   mul_b = {{(MUL_B_W-PIX_W){1'b0}}, pix_mag};
         B_ZF:    mul_b = {1'b0, zf_ff};
         B_K:     mul_b = k_val;
         B_WIN:   mul_b = {{(MUL_B_W-WIN_W){1'b0}}, (cw.axis ? win_h_ff : win_w_ff)};
         default: mul_b = '0;
      endcase
   end

   // ---------------------------------------------------------------- origin update
   logic [POS_W-1:0]   term_mag;
   logic               term_neg;
   logic [POS_W-1:0]   term;
   logic [POS_W-1:0]   org_next;

   assign term_mag = cw.sh16 ? POS_W'(prod_ff >> FRAC_W) : POS_W'(prod_ff);
   assign term_neg = sign_ff ^ (cw.acc == ACC_SUB);
   assign term     = term_neg ? (POS_W'(0) - term_mag) : term_mag;

   always_comb begin
      case (cw.acc)
         ACC_INIT: org_next = POS_W'(0) - POS_W'(prod_ff >> 1);
         default:  org_next = org_sel + term;
      endcase
   end

   // ---------------------------------------------------------------- screen clamp
   logic [SCR_W-1:0]   quo_lo;
   logic               quo_sat;
   logic [SCR_W-1:0]   scr_val;

   assign quo_lo  = div_quo[SCR_W-1:0];
   assign quo_sat = div_stat.ovf || (|div_quo[SCALE_W-1:SCR_W])
                    || (neg_ff ? (quo_lo > SCR_NEG_LIMIT) : (quo_lo > SCR_POS_LIMIT));
   always_comb begin
      if (neg_ff) begin
         scr_val = quo_sat ? SCR_NEG_LIMIT : SCR_W'(SCR_W'(0) - quo_lo);
      end else begin
         scr_val = quo_sat ? SCR_POS_LIMIT : quo_lo;
      end
   end

   // ---------------------------------------------------------------- jumps
   always_comb begin
      case (cw.jmp)
         J_NS_LOW:  take_jump = (ns_ff == '0) || (ns_ff < min_ff);
         J_ZF_ZERO: take_jump = zf_ff == '0;
         J_NS_HIGH: take_jump = div_stat.ovf || (ns_ff > max_ff);
         default:   take_jump = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      zf_in         = zf_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      init_in       = init_ff;
      win_w_in      = win_w_ff;
      win_h_in      = win_h_ff;
      org_x_in      = org_x_ff;
      org_y_in      = org_y_ff;
      view_scale_in = view_scale_ff;
      run_in        = run_ff;
      upc_in        = upc_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      prod_in       = prod_ff;
      ns_in         = ns_ff;
      sign_in       = sign_ff;
      neg_in        = neg_ff;
      scr_x_in      = scr_x_ff;
      scr_y_in      = scr_y_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_st_in     = out_st_ff;

      // register writes; indexes past the list drop
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ZOOM_FACTOR:   zf_in    = csr_ch.data[ZF_W-1:0];
            CSR_MIN_SCALE:     min_in   = csr_ch.data[SCALE_W-1:0];
            CSR_MAX_SCALE:     max_in   = csr_ch.data[SCALE_W-1:0];
            CSR_INITIAL_SCALE: init_in  = csr_ch.data[SCALE_W-1:0];
            CSR_WINDOW_WIDTH:  win_w_in = csr_ch.data[WIN_W-1:0];
            CSR_WINDOW_HEIGHT: win_h_in = csr_ch.data[WIN_W-1:0];
            default: ;
         endcase
      end

      // retire a delivered response
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // take a request: latch the beat and enter its program
      if (req_fire) begin
         run_in   = 1'b1;
         upc_in   = entry_addr(req_ch.req_type);
         px_in    = req_ch.pixel_x;
         py_in    = req_ch.pixel_y;
         bx_in    = req_ch.body_x;
         by_in    = req_ch.body_y;
         scr_x_in = '0;
         scr_y_in = '0;
         stat_in  = ST_OK;
      end

      if (step) begin
         if (cw.mul_en) begin
            prod_in = {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};
            if (cw.b_sel == B_PIX) begin
               sign_in = pix_neg;
            end
         end

         if (cw.div_op == DIV_PROJ) begin
            neg_in = dist_neg;
         end

         if (cw.acc != ACC_NONE) begin
            if (cw.axis) begin
               org_y_in = org_next;
            end else begin
               org_x_in = org_next;
            end
         end

         case (cw.ns_sel)
            NS_MUL:  ns_in = prod_ff[FRAC_W+SCALE_W-1:FRAC_W];
            NS_DIV:  ns_in = div_quo;
            default: ;
         endcase

         case (cw.sc_sel)
            SC_NS:   view_scale_in = ns_ff;
            SC_INIT: view_scale_in = (init_ff == '0) ? SCALE_W'(1) : init_ff;
            default: ;
         endcase

         if (cw.store_scr) begin
            if (cw.axis) begin
               scr_y_in = scr_val;
            end else begin
               scr_x_in = scr_val;
            end
            if (quo_sat) begin
               stat_in = ST_SAT;
            end
         end

         if (cw.refuse) begin
            stat_in = ST_REFUSE;
         end

         // advance the step counter; last step hands the beat to the output register
         if (cw.finish) begin
            run_in       = 1'b0;
            rsp_valid_in = 1'b1;
            out_x_in     = scr_x_in;
            out_y_in     = scr_y_in;
            out_st_in    = stat_in;
         end else if (take_jump) begin
            upc_in = cw.target;
         end else begin
            upc_in = upc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zf_ff         <= ZF_RESET;
         min_ff        <= MIN_RESET;
         max_ff        <= MAX_RESET;
         init_ff       <= SCALE_RESET;
         win_w_ff      <= WIDTH_RESET;
         win_h_ff      <= HEIGHT_RESET;
         org_x_ff      <= ORIGIN_X_RESET;
         org_y_ff      <= ORIGIN_Y_RESET;
         view_scale_ff <= SCALE_RESET;
         run_ff        <= 1'b0;
         upc_ff        <= UA_DONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         zf_ff         <= zf_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         init_ff       <= init_in;
         win_w_ff      <= win_w_in;
         win_h_ff      <= win_h_in;
         org_x_ff      <= org_x_in;
         org_y_ff      <= org_y_in;
         view_scale_ff <= view_scale_in;
         run_ff        <= run_in;
         upc_ff        <= upc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      px_ff     <= px_in;
      py_ff     <= py_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      prod_ff   <= prod_in;
      ns_ff     <= ns_in;
      sign_ff   <= sign_in;
      neg_ff    <= neg_in;
      scr_x_ff  <= scr_x_in;
      scr_y_ff  <= scr_y_in;
      stat_ff   <= stat_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_st_ff <= out_st_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_ch.ready    = !run_ff;
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.screen_x = out_x_ff;
   assign rsp_ch.screen_y = out_y_ff;
   assign rsp_ch.status   = out_st_ff;

   // ---------------------------------------------------------------- assertions
   // the divider only runs under a request that waits for it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> run_ff)
      else $error("divider busy with no request in flight");

   // scale is never zero, so a projection never divides by zero
   a_scale_nonzero: assert property (@(posedge clock) disable iff (reset)
      view_scale_ff != '0)
      else $error("view scale reached zero");

   // a taken request starts the sequencer
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> run_ff)
      else $error("request accepted but sequencer idle");

   // a refused zoom reports a zero screen position
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == ST_REFUSE))
      |-> (rsp_ch.screen_x == '0) && (rsp_ch.screen_y == '0))
      else $error("refused request carries a screen position");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the zoom and pan viewport projector.
`timescale 1ns / 100ps
module tb_top;
   import zpv_pkg::*;

   // Request codes the block must ignore
   localparam logic [2:0] REQ_SPARE_A = 3'd5;
   localparam logic [2:0] REQ_SPARE_B = 3'd6;
   localparam logic [2:0] REQ_SPARE_C = 3'd7;
   // Register index with nothing behind it
   localparam logic [IDX_W-1:0] CSR_UNMAPPED = 3'd6;

   localparam logic [SCALE_W-1:0]      SCALE_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [POS_W-1:0]        BODY_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [POS_W-1:0]        BODY_MIN  = 64'h8000_0000_0000_0000;
   localparam logic signed [PIX_W-1:0] PIX_MAX   = 13'h0FFF;
   localparam logic signed [PIX_W-1:0] PIX_MIN   = 13'h1000;
   localparam logic signed [PIX_W-1:0] PIX_NEG1  = 13'h1FFF;

   localparam int HOLD_CYCLES  = 300;   // long receiver stall
   localparam int DRAIN_CYCLES = 100;   // past the slowest request (zoom out)
   localparam int DRIFT_PANS   = 20;    // drift requests at the widest scale, mostly full-scale pans

   typedef struct {
      logic [2:0]              kind;
      logic signed [PIX_W-1:0] px;
      logic signed [PIX_W-1:0] py;
      logic [POS_W-1:0]        bx;
      logic [POS_W-1:0]        by;
   } view_req_type;

   typedef struct {
      logic [SCR_W-1:0] sx;
      logic [SCR_W-1:0] sy;
      status_type       st;
   } screen_rsp_type;

   typedef struct {
      view_req_type   req;
      bit             fixed;   // expected beat typed in below, else taken from the predictor
      screen_rsp_type rsp;
   } dir_row_type;

   logic clock;
   logic reset;

   zpv_req_if req_ch ();
   zpv_rsp_if rsp_ch ();
   zpv_csr_if csr_ch ();

   zoom_pan_viewport_projector dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted view state and register copies
   logic [ZF_W-1:0]    cfg_zf;
   logic [SCALE_W-1:0] cfg_min;
   logic [SCALE_W-1:0] cfg_max;
   logic [SCALE_W-1:0] cfg_init;
   logic [WIN_W-1:0]   cfg_w;
   logic [WIN_W-1:0]   cfg_h;
   logic [POS_W-1:0]   view_org_x;
   logic [POS_W-1:0]   view_org_y;
   logic [SCALE_W-1:0] cur_scale;

   screen_rsp_type awaited_screens [$];
   screen_rsp_type seen_want;
   screen_rsp_type unused_rsp;
   int             fail_count;
   bit             no_gaps;
   int             rsp_holds_asked;
   int             rsp_holds_done;
   int             hold_left;

   // Directed table, walked once right after reset (reset view: scale 1.0,
   // origin at (-512, -384) pixels).
   dir_row_type dir_rows [21] = '{
      // body on the origin lands on pixel zero
      '{'{REQ_PROJECT, '0, '0, ORIGIN_X_RESET, ORIGIN_Y_RESET}, 1'b1,
        '{16'd0, 16'd0, ST_OK}},
      // world zero is the window center
      '{'{REQ_PROJECT, '0, '0, 64'd0, 64'd0}, 1'b1, '{16'd512, 16'd384, ST_OK}},
      // extreme bodies saturate both ways
      '{'{REQ_PROJECT, '0, '0, BODY_MAX, BODY_MIN}, 1'b1,
        '{SCR_POS_LIMIT, SCR_NEG_LIMIT, ST_SAT}},
      '{'{REQ_PROJECT, '0, '0, BODY_MIN, BODY_MAX}, 1'b1,
        '{SCR_NEG_LIMIT, SCR_POS_LIMIT, ST_SAT}},
      // exactly on the screen limits, then one pixel past them
      '{'{REQ_PROJECT, '0, '0, 64'h0000_0000_7DFF_0000, 64'hFFFF_FFFF_7E80_0000}, 1'b1,
        '{SCR_POS_LIMIT, SCR_NEG_LIMIT, ST_OK}},
      '{'{REQ_PROJECT, '0, '0, 64'h0000_0000_7E00_0000, 64'hFFFF_FFFF_7E7F_0000}, 1'b1,
        '{SCR_POS_LIMIT, SCR_NEG_LIMIT, ST_SAT}},
      // fractions of a pixel truncate toward zero on both sides
      '{'{REQ_PROJECT, '0, '0, 64'hFFFF_FFFF_FE00_FFFF, 64'hFFFF_FFFF_FE7F_FFFF}, 1'b1,
        '{16'd0, 16'd0, ST_OK}},
      // unknown codes leave the view alone and answer zeros
      '{'{REQ_SPARE_A, PIX_MAX, PIX_MIN, BODY_MAX, BODY_MIN}, 1'b1,
        '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_SPARE_B, PIX_MIN, PIX_MAX, BODY_MIN, BODY_MAX}, 1'b1,
        '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_SPARE_C, PIX_NEG1, '0, 64'd0, 64'd0}, 1'b1, '{16'd0, 16'd0, ST_OK}},
      // full-range pan
      '{'{REQ_PAN, PIX_MAX, PIX_MIN, 64'd0, 64'd0}, 1'b1, '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_PROJECT, '0, '0, 64'd0, 64'd0}, 1'b0, '{16'd0, 16'd0, ST_OK}},
      // zoom about the corner and extreme cursors
      '{'{REQ_ZOOM_IN, '0, '0, 64'd0, 64'd0}, 1'b0, '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_ZOOM_IN, PIX_MIN, PIX_MAX, 64'd0, 64'd0}, 1'b0, '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_ZOOM_OUT, PIX_MAX, PIX_MIN, 64'd0, 64'd0}, 1'b0, '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_ZOOM_OUT, '0, '0, 64'd0, 64'd0}, 1'b0, '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_PROJECT, '0, '0, 64'h0000_0000_0123_4567, 64'hFFFF_FFFF_FFED_CBA9}, 1'b0,
        '{16'd0, 16'd0, ST_OK}},
      // init recenters at the reset scale
      '{'{REQ_INIT, PIX_NEG1, PIX_NEG1, 64'd0, 64'd0}, 1'b1, '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_PROJECT, '0, '0, ORIGIN_X_RESET, ORIGIN_Y_RESET}, 1'b1,
        '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_PAN, PIX_NEG1, 13'd1, 64'd0, 64'd0}, 1'b1, '{16'd0, 16'd0, ST_OK}},
      '{'{REQ_PROJECT, '0, '0, 64'd0, 64'd0}, 1'b0, '{16'd0, 16'd0, ST_OK}}
   };

   // ---------------------------------------------------------------- predictor

   // Distance from origin over scale, truncated, clamped to the 16-bit screen.
   function automatic logic [SCR_W-1:0] axis_to_pixel(input logic [POS_W-1:0] body,
                                                      input logic [POS_W-1:0] org,
                                                      inout bit sat);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] q;
      neg = $signed(body) < $signed(org);
      mag = neg ? org - body : body - org;
      q = mag / {24'd0, cur_scale};
      if (!neg) begin
         if (q > 64'd32767) begin
            sat = 1'b1;
            q = 64'd32767;
         end
      end else begin
         if (q > 64'd32768) begin
            sat = 1'b1;
            q = 64'd32768;
         end
         q = 64'd0 - q;
      end
      return q[SCR_W-1:0];
   endfunction

   // trunc(p * k / 65536), split so nothing overflows 64 bits
   function automatic logic [63:0] frac_of(input logic signed [63:0] p,
                                           input logic [63:0] k);
      logic [63:0] m;
      logic [63:0] r;
      m = (p < 0) ? 64'd0 - p : p;
      r = (m >> 16) * k + (((m & 64'hFFFF) * k) >> 16);
      return (p < 0) ? 64'd0 - r : r;
   endfunction

   function automatic void center_view();
      cur_scale  = (cfg_init == '0) ? 40'd1 : cfg_init;
      view_org_x = 64'd0 - (({51'd0, cfg_w} * {24'd0, cur_scale}) >> 1);
      view_org_y = 64'd0 - (({51'd0, cfg_h} * {24'd0, cur_scale}) >> 1);
   endfunction

   // Apply one request to the predicted view and return the beat it answers with.
   function automatic screen_rsp_type step_viewport(input view_req_type r);
      screen_rsp_type     o;
      bit                 sat;
      logic [63:0]        s64;
      logic [63:0]        ns;
      logic [63:0]        k;
      logic signed [63:0] pxs;
      logic signed [63:0] pys;
      o.sx = '0;
      o.sy = '0;
      o.st = ST_OK;
      sat = 1'b0;
      s64 = {24'd0, cur_scale};
      k   = 64'd65536 - {48'd0, cfg_zf};
      pxs = r.px;
      pys = r.py;
      case (r.kind)
         REQ_PROJECT: begin
            o.sx = axis_to_pixel(r.bx, view_org_x, sat);
            o.sy = axis_to_pixel(r.by, view_org_y, sat);
            if (sat) o.st = ST_SAT;
         end
         REQ_ZOOM_IN: begin
            ns = (s64 * {48'd0, cfg_zf}) >> 16;
            if (ns == 64'd0 || ns < {24'd0, cfg_min}) begin
               o.st = ST_REFUSE;
            end else begin
               // cursor point stays put: shift by the old scale
               view_org_x = view_org_x + frac_of(pxs * $signed(s64), k);
               view_org_y = view_org_y + frac_of(pys * $signed(s64), k);
               cur_scale  = ns[SCALE_W-1:0];
            end
         end
         REQ_ZOOM_OUT: begin
            if (cfg_zf == '0) begin
               o.st = ST_REFUSE;
            end else begin
               ns = (s64 << 16) / {48'd0, cfg_zf};
               if (ns > {24'd0, SCALE_MAX} || ns > {24'd0, cfg_max}) begin
                  o.st = ST_REFUSE;
               end else begin
                  // here the shift uses the new scale
                  cur_scale  = ns[SCALE_W-1:0];
                  view_org_x = view_org_x - frac_of(pxs * $signed(ns), k);
                  view_org_y = view_org_y - frac_of(pys * $signed(ns), k);
               end
            end
         end
         REQ_PAN: begin
            view_org_x = view_org_x + pxs * $signed(s64);
            view_org_y = view_org_y + pys * $signed(s64);
         end
         REQ_INIT: center_view();
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [PIX_W-1:0] draw_pixel();
      case ($urandom_range(19))
         0: return PIX_MIN;
         1: return PIX_MAX;
         2: return '0;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Mostly bodies a few screens around the origin, some right on the clamp
   // edges, some anywhere in the world.
   function automatic logic [POS_W-1:0] draw_body(input logic [POS_W-1:0] org);
      logic [63:0]        s64;
      logic [63:0]        frac;
      logic signed [63:0] steps;
      int                 off;
      s64  = {24'd0, cur_scale};
      frac = {$urandom, $urandom} % s64;
      case ($urandom_range(9))
         7: begin
            case ($urandom_range(3))
               0: off = 32767;
               1: off = 32768;
               2: off = -32768;
               default: off = -32769;
            endcase
         end
         8, 9: return {$urandom, $urandom};
         default: off = int'($urandom_range(80000)) - 40000;
      endcase
      steps = off;
      return org + steps * $signed(s64) + frac;
   endfunction

   function automatic view_req_type plain_req(input logic [2:0] kind);
      view_req_type r;
      r.kind = kind;
      r.px   = draw_pixel();
      r.py   = draw_pixel();
      r.bx   = {$urandom, $urandom};
      r.by   = {$urandom, $urandom};
      return r;
   endfunction

   function automatic view_req_type draw_req();
      view_req_type r;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         r = plain_req(REQ_PROJECT);
         r.bx = draw_body(view_org_x);
         r.by = draw_body(view_org_y);
      end else if (pick < 56) begin
         r = plain_req(REQ_ZOOM_IN);
      end else if (pick < 72) begin
         r = plain_req(REQ_ZOOM_OUT);
      end else if (pick < 90) begin
         r = plain_req(REQ_PAN);
      end else if (pick < 95) begin
         r = plain_req(REQ_INIT);
      end else begin
         case ($urandom_range(2))
            0: r = plain_req(REQ_SPARE_A);
            1: r = plain_req(REQ_SPARE_B);
            default: r = plain_req(REQ_SPARE_C);
         endcase
      end
      return r;
   endfunction

   // Offer one request beat (entered and left at a falling edge), then predict it.
   task automatic send_req(input view_req_type r, input bit fixed,
                           input screen_rsp_type want);
      screen_rsp_type guess;
      if (!no_gaps && $urandom_range(99) < 32) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 50)) @(negedge clock);
      end
      req_ch.req_type = r.kind;
      req_ch.pixel_x  = r.px;
      req_ch.pixel_y  = r.py;
      req_ch.body_x   = r.bx;
      req_ch.body_y   = r.by;
      req_ch.valid    = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      guess = step_viewport(r);
      awaited_screens.push_back(fixed ? want : guess);
      @(negedge clock);
   endtask

   // Drop valid and hold until every predicted beat has come back.
   task automatic settle();
      req_ch.valid = 1'b0;
      while (awaited_screens.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data  = val;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_ZOOM_FACTOR:   cfg_zf   = val[ZF_W-1:0];
         CSR_MIN_SCALE:     cfg_min  = val[SCALE_W-1:0];
         CSR_MAX_SCALE:     cfg_max  = val[SCALE_W-1:0];
         CSR_INITIAL_SCALE: cfg_init = val[SCALE_W-1:0];
         CSR_WINDOW_WIDTH:  cfg_w    = val[WIN_W-1:0];
         CSR_WINDOW_HEIGHT: cfg_h    = val[WIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic load_view_cfg(input logic [ZF_W-1:0] zf,
                                input logic [SCALE_W-1:0] mn,
                                input logic [SCALE_W-1:0] mx,
                                input logic [SCALE_W-1:0] ini,
                                input logic [WIN_W-1:0] w,
                                input logic [WIN_W-1:0] h);
      write_csr(CSR_ZOOM_FACTOR, CSR_W'(zf));
      write_csr(CSR_MIN_SCALE, mn);
      write_csr(CSR_MAX_SCALE, mx);
      write_csr(CSR_INITIAL_SCALE, ini);
      write_csr(CSR_WINDOW_WIDTH, CSR_W'(w));
      write_csr(CSR_WINDOW_HEIGHT, CSR_W'(h));
   endtask

   // Recenter under the new settings, then a run of random requests.
   task automatic run_random(input int count);
      send_req(plain_req(REQ_INIT), 1'b0, unused_rsp);
      repeat (count) send_req(draw_req(), 1'b0, unused_rsp);
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string what, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t %s differs: expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   // Compare every accepted response beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_screens.size() == 0) begin
            fail_count++;
            $display("%0t stray response beat: expected none, got x=%0d y=%0d status=%0d",
                     $time, $signed(rsp_ch.screen_x), $signed(rsp_ch.screen_y),
                     rsp_ch.status);
         end else begin
            seen_want = awaited_screens.pop_front();
            check_field("screen_x", int'($signed(seen_want.sx)), int'($signed(rsp_ch.screen_x)));
            check_field("screen_y", int'($signed(seen_want.sy)), int'($signed(rsp_ch.screen_y)));
            check_field("status", int'(seen_want.st), int'(rsp_ch.status));
         end
      end
   end

   // ---------------------------------------------------------------- clocks and sides

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random backpressure, plus one long hold-off on request from the main flow.
   initial begin
      rsp_ch.ready   = 1'b0;
      rsp_holds_done = 0;
      hold_left      = 0;
      forever begin
         @(negedge clock);
         if (rsp_holds_done != rsp_holds_asked) begin
            rsp_holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = no_gaps || ($urandom_range(99) >= 32);
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("zoom_pan_viewport_projector: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- main flow

   initial begin
      view_req_type       r;
      logic [SCALE_W-1:0] mn;
      logic [SCALE_W-1:0] mx;
      logic [SCALE_W-1:0] ini;

      // Hold everything at known values with reset high, then release reset at a falling edge.
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_PROJECT;
      req_ch.pixel_x  = '0;
      req_ch.pixel_y  = '0;
      req_ch.body_x   = '0;
      req_ch.body_y   = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_ZOOM_FACTOR;
      csr_ch.data     = '0;
      fail_count      = 0;
      no_gaps         = 1'b0;
      rsp_holds_asked = 0;
      unused_rsp      = '{'0, '0, ST_OK};
      cfg_zf          = ZF_RESET;
      cfg_min         = MIN_RESET;
      cfg_max         = MAX_RESET;
      cfg_init        = SCALE_RESET;
      cfg_w           = WIDTH_RESET;
      cfg_h           = HEIGHT_RESET;
      center_view();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table at the reset settings.
      foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

      // Reset settings, random traffic with the pressure points:
      // a long receiver stall while requests keep coming, a full drain
      // mid-stream, and a stretch where neither side idles.
      for (int n = 0; n < 220; n++) begin
         if (n == 60) rsp_holds_asked++;
         if (n == 120) settle();
         no_gaps = (n >= 140 && n < 200);
         send_req(draw_req(), 1'b0, unused_rsp);
      end

      // Zero factor, unit initial scale: every zoom is refused.
      settle();
      load_view_cfg(16'd0, 40'd1, SCALE_MAX, 40'd1, 13'd1, 13'd4096);
      run_random(50);

      // Finest step and widest scale: zoom out overruns 40 bits.
      settle();
      load_view_cfg(16'hFFFF, 40'd1, SCALE_MAX, SCALE_MAX, 13'd4096, 13'd1);
      run_random(60);

      // Coarsest step with the limits pinched shut.
      settle();
      load_view_cfg(16'd1, SCALE_MAX, 40'd1, SCALE_RESET, 13'd4096, 13'd4096);
      run_random(40);

      // Halving step from a tiny scale: zoom in drives the new scale to zero and is refused.
      settle();
      load_view_cfg(16'h8000, 40'd1, SCALE_MAX, 40'd2, 13'($urandom_range(1, 4096)),
                    13'($urandom_range(1, 4096)));
      run_random(50);

      // Random settings, the unused index poked once along the way.
      for (int p = 0; p < 4; p++) begin
         mn  = 40'($urandom_range(1, 65536));
         mx  = mn + 40'($urandom);
         ini = mn + 40'({32'd0, $urandom} % ({24'd0, mx - mn} + 64'd1));
         settle();
         if (p == 0) write_csr(CSR_UNMAPPED, {$urandom, $urandom});
         load_view_cfg(16'($urandom_range(1, 65535)), mn, mx, ini,
                       13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
         run_random(55);
      end

      // Drift: full-scale pans in one direction, with a projection
      // every so often.
      settle();
      load_view_cfg(cfg_zf, 40'd1, SCALE_MAX, SCALE_MAX, 13'd4096, 13'd4096);
      send_req(plain_req(REQ_INIT), 1'b0, unused_rsp);
      for (int n = 0; n < DRIFT_PANS; n++) begin
         if (n % 10 == 9) begin
            r = plain_req(REQ_PROJECT);
            r.bx = draw_body(view_org_x);
            r.by = draw_body(view_org_y);
         end else begin
            r = plain_req(REQ_PAN);
            r.px = PIX_MAX;
            r.py = PIX_MIN;
         end
         send_req(r, 1'b0, unused_rsp);
      end

      // Drain, then give stray beats a chance to show up.
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("zoom_pan_viewport_projector: match");
      else
         $display("zoom_pan_viewport_projector: mismatch");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/zpv_pkg.sv
rtl/core/zpv_if.sv
rtl/core/zpv_divider.sv
rtl/core/zoom_pan_viewport_projector.sv
sim/tb_top.sv
